// ----- src/rgb_to_hsv_8bit_macros.svh -----
// Assertion macros used by the back end of the HSV converter RTL
`ifndef RGB_TO_HSV_8BIT_MACROS_SVH
`define RGB_TO_HSV_8BIT_MACROS_SVH

// Same-cycle implication, gated off during reset
`define RHSV_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("rgb_to_hsv_8bit: same-cycle check failed");

// Next-cycle implication, gated off during reset
`define RHSV_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("rgb_to_hsv_8bit: next-cycle check failed");

`endif

// ----- src/rgb_hsv_pkg.sv -----
// Types, constants and helper functions of the RGB to HSV converter
`timescale 1ns / 1ps
`default_nettype none

package rgb_hsv_pkg;

    // Request payloads
    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_rgb;

    typedef struct packed {
        logic [7:0] hue;
        logic [7:0] saturation;
        logic [7:0] brightness;
    } t_hsv;

    // Hue sector codes
    localparam logic [1:0] SEC_RED   = 2'd0;
    localparam logic [1:0] SEC_GREEN = 2'd1;
    localparam logic [1:0] SEC_BLUE  = 2'd2;

    localparam logic [7:0] OFS_RED   = 8'd0;
    localparam logic [7:0] OFS_GREEN = 8'd85;
    localparam logic [7:0] OFS_BLUE  = 8'd171;

    localparam logic [15:0] SECTOR_STEP = 16'd43;

    // Divider operand: remainder, divisor and quotient built so far
    typedef struct packed {
        logic [15:0] rem;
        logic [7:0]  den;
        logic [7:0]  quo;
    } t_div;

    // Per-pixel side information carried alongside the dividers
    typedef struct packed {
        logic [1:0] sector;
        logic       neg;
        logic       grey;
        logic [7:0] bright;
    } t_side;

    typedef struct packed {
        t_div  hue;
        t_div  sat;
        t_side side;
    } t_div_bus;

    // One restoring step: try to take den << k off the remainder
    function automatic t_div div_step(input t_div x, input logic [2:0] k);
        logic [15:0] sub;
        t_div        res;
        sub = 16'(x.den) << k;
        res = x;
        if (x.rem >= sub) begin
            res.rem    = x.rem - sub;
            res.quo[k] = 1'b1;
        end
        return res;
    endfunction

    function automatic logic [7:0] sector_offset(input logic [1:0] sector);
        logic [7:0] ofs;
        case (sector)
            SEC_RED:   ofs = OFS_RED;
            SEC_GREEN: ofs = OFS_GREEN;
            SEC_BLUE:  ofs = OFS_BLUE;
            default:   ofs = OFS_RED;
        endcase
        return ofs;
    endfunction

endpackage

`default_nettype wire

// ----- src/rgb_to_hsv_8bit.sv -----
// Top level of the pipelined 8-bit RGB to HSV pixel converter
`timescale 1ns / 1ps
`default_nettype none

// Usage
//   Input channel: present one RGB pixel on i_pixel with i_valid; the request
//   is taken at a rising edge where i_valid and o_ready are both high.
//   Output channel: o_hsv carries hue, saturation and brightness with o_valid;
//   the request is handed over at an edge where o_valid and i_ready are high.
//   Stages: seven register stages lie between acceptance and o_valid
//   (extremes, dividends, four two-bit divider stages, output register).
//   Throughput: one pixel per clock while the receiver keeps i_ready high; no
//   pixel depends on an earlier one.
//   Stall: every stage holds its request when the stage after it is full and
//   stalled, and an empty stage keeps taking requests, so bubbles are squeezed
//   out before o_ready drops. Nothing is dropped or repeated.
//   Reset: synchronous, active low on i_rst_n; clears every valid bit, so the
//   pipeline comes up empty with o_valid low and o_ready high.
module rgb_to_hsv_8bit (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_valid,
    output logic               o_ready,
    input  rgb_hsv_pkg::t_rgb  i_pixel,
    output logic               o_valid,
    input  wire                i_ready,
    output rgb_hsv_pkg::t_hsv  o_hsv
);

    localparam int N_DIV = 4;

    // Handshake and payload between stages: index 0 leaves the front end
    logic [N_DIV:0]        w_vld;
    logic [N_DIV:0]        w_rdy;
    rgb_hsv_pkg::t_div_bus w_bus [N_DIV+1];

    // Extremes and sector, then the two dividends
    rgb_hsv_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_pixel (i_pixel),
        .o_valid (w_vld[0]),
        .i_ready (w_rdy[0]),
        .o_bus   (w_bus[0])
    );

    // Four divider stages, quotient bits seven down to zero, two per stage
    for (genvar g = 0; g < N_DIV; g++) begin : g_div
        rgb_hsv_div_stg #(
            .HI_BIT (7 - 2 * g)
        ) u_div (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (w_vld[g]),
            .o_ready (w_rdy[g]),
            .i_bus   (w_bus[g]),
            .o_valid (w_vld[g+1]),
            .i_ready (w_rdy[g+1]),
            .o_bus   (w_bus[g+1])
        );
    end

    // Finish the hue and hold the result for the receiver
    rgb_hsv_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_vld[N_DIV]),
        .o_ready (w_rdy[N_DIV]),
        .i_bus   (w_bus[N_DIV]),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_hsv   (o_hsv)
    );

endmodule

`default_nettype wire

// ----- src/rgb_hsv_front.sv -----
// Front end: extremes, sector choice, then the scaled dividends
`timescale 1ns / 1ps
`default_nettype none

module rgb_hsv_front (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  wire                    i_valid,
    output logic                   o_ready,
    input  rgb_hsv_pkg::t_rgb      i_pixel,
    output logic                   o_valid,
    input  wire                    i_ready,
    output rgb_hsv_pkg::t_div_bus  o_bus
);

    // Stage one registers
    logic              r_v1;
    logic [7:0]        r_max;
    logic [7:0]        r_spread;
    logic signed [8:0] r_diff;
    logic [1:0]        r_sector;

    // Stage two registers
    logic                  r_v2;
    rgb_hsv_pkg::t_div_bus r_bus;

    logic              w_rdy2;
    logic              w_en1;
    logic              w_en2;
    logic [7:0]        n_max;
    logic [7:0]        n_min;
    logic signed [8:0] n_diff;
    logic [1:0]        n_sector;
    logic [7:0]        w_abs;
    rgb_hsv_pkg::t_div_bus n_bus;

    assign w_rdy2  = !r_v2 || i_ready;
    assign o_ready = !r_v1 || w_rdy2;
    assign w_en1   = o_ready;
    assign w_en2   = w_rdy2;

    // Red wins ties, then green
    always_comb begin
        if (i_pixel.red >= i_pixel.green && i_pixel.red >= i_pixel.blue) begin
            n_sector = rgb_hsv_pkg::SEC_RED;
            n_max    = i_pixel.red;
            n_diff   = $signed({1'b0, i_pixel.green}) - $signed({1'b0, i_pixel.blue});
        end else if (i_pixel.green >= i_pixel.blue) begin
            n_sector = rgb_hsv_pkg::SEC_GREEN;
            n_max    = i_pixel.green;
            n_diff   = $signed({1'b0, i_pixel.blue}) - $signed({1'b0, i_pixel.red});
        end else begin
            n_sector = rgb_hsv_pkg::SEC_BLUE;
            n_max    = i_pixel.blue;
            n_diff   = $signed({1'b0, i_pixel.red}) - $signed({1'b0, i_pixel.green});
        end
        n_min = (i_pixel.red < i_pixel.green) ? i_pixel.red : i_pixel.green;
        if (i_pixel.blue < n_min) begin
            n_min = i_pixel.blue;
        end
    end

    // Magnitude of the difference, then both dividends
    always_comb begin
        w_abs = r_diff[8] ? 8'(-r_diff) : r_diff[7:0];
        n_bus.hue.rem     = 16'(w_abs) * rgb_hsv_pkg::SECTOR_STEP;
        n_bus.hue.den     = r_spread;
        n_bus.hue.quo     = 8'd0;
        n_bus.sat.rem     = {r_spread, 8'd0} - 16'(r_spread);
        n_bus.sat.den     = r_max;
        n_bus.sat.quo     = 8'd0;
        n_bus.side.sector = r_sector;
        n_bus.side.neg    = r_diff[8];
        n_bus.side.grey   = (r_spread == 8'd0);
        n_bus.side.bright = r_max;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            if (w_en1) begin
                r_v1 <= i_valid;
            end
            if (w_en2) begin
                r_v2 <= r_v1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en1 && i_valid) begin
            r_max    <= n_max;
            r_spread <= n_max - n_min;
            r_diff   <= n_diff;
            r_sector <= n_sector;
        end
        if (w_en2 && r_v1) begin
            r_bus <= n_bus;
        end
    end

    assign o_valid = r_v2;
    assign o_bus   = r_bus;

endmodule

`default_nettype wire

// ----- src/rgb_hsv_div_stg.sv -----
// One divider stage: two restoring steps for both quotients
`timescale 1ns / 1ps
`default_nettype none

module rgb_hsv_div_stg #(
    parameter int HI_BIT = 7
) (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  wire                    i_valid,
    output logic                   o_ready,
    input  rgb_hsv_pkg::t_div_bus  i_bus,
    output logic                   o_valid,
    input  wire                    i_ready,
    output rgb_hsv_pkg::t_div_bus  o_bus
);

    localparam logic [2:0] K_HI = 3'(HI_BIT);
    localparam logic [2:0] K_LO = 3'(HI_BIT - 1);

    logic                  r_valid;
    rgb_hsv_pkg::t_div_bus r_bus;
    rgb_hsv_pkg::t_div_bus n_bus;

    assign o_ready = !r_valid || i_ready;

    always_comb begin
        n_bus      = i_bus;
        n_bus.hue  = rgb_hsv_pkg::div_step(rgb_hsv_pkg::div_step(i_bus.hue, K_HI), K_LO);
        n_bus.sat  = rgb_hsv_pkg::div_step(rgb_hsv_pkg::div_step(i_bus.sat, K_HI), K_LO);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_bus <= n_bus;
        end
    end

    assign o_valid = r_valid;
    assign o_bus   = r_bus;

endmodule

`default_nettype wire

// ----- src/rgb_hsv_back.sv -----
// Back end: sign and sector offset on the hue, output register
`timescale 1ns / 1ps
`default_nettype none

`include "rgb_to_hsv_8bit_macros.svh"

module rgb_hsv_back (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  wire                    i_valid,
    output logic                   o_ready,
    input  rgb_hsv_pkg::t_div_bus  i_bus,
    output logic                   o_valid,
    input  wire                    i_ready,
    output rgb_hsv_pkg::t_hsv      o_hsv
);

    logic              r_valid;
    rgb_hsv_pkg::t_hsv r_out;
    rgb_hsv_pkg::t_hsv n_out;
    logic [7:0]        w_step;

    assign o_ready = !r_valid || i_ready;

    // Truncation toward zero: negate the magnitude quotient
    always_comb begin
        w_step = i_bus.side.neg ? (8'd0 - i_bus.hue.quo) : i_bus.hue.quo;
        if (i_bus.side.grey) begin
            n_out.hue = 8'd0;
        end else begin
            n_out.hue = rgb_hsv_pkg::sector_offset(i_bus.side.sector) + w_step;
        end
        n_out.saturation = (i_bus.side.bright == 8'd0) ? 8'd0 : i_bus.sat.quo;
        n_out.brightness = i_bus.side.bright;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_out <= n_out;
        end
    end

    assign o_valid = r_valid;
    assign o_hsv   = r_out;

    `RHSV_ASSERT_IMPLY(a_hue_quo_range, i_clk, i_rst_n, i_valid && !i_bus.side.grey, i_bus.hue.quo <= 8'd43)
    `RHSV_ASSERT_IMPLY(a_hue_rem_below, i_clk, i_rst_n, i_valid && !i_bus.side.grey, i_bus.hue.rem < 16'(i_bus.hue.den))
    `RHSV_ASSERT_NEXT(a_black_out, i_clk, i_rst_n, i_valid && o_ready && i_bus.side.bright == 8'd0, r_out.hue == 8'd0 && r_out.saturation == 8'd0)

endmodule

`default_nettype wire

// ----- sim/rgb_to_hsv_8bit_tb.sv -----
// Self-checking testbench of the 8-bit RGB to HSV converter, random idling on both channels
`timescale 1ns / 1ps

module rgb_to_hsv_8bit_tb;

    localparam int CLK_HALF    = 4;
    localparam int RESET_LEN   = 11;
    localparam int MAX_IDLE    = 11;
    localparam int RANDOM_PIX  = 800;
    localparam int FLUSH_LEN   = 16;      // pipeline is seven deep, allow margin
    localparam int CYCLE_LIMIT = 200000;

    localparam int HUE_STEP    = int'(rgb_hsv_pkg::SECTOR_STEP);
    localparam int FULL_SCALE  = 255;

    // One pending request: pixel, idle cycles before it, and whether to
    // hold it back until the converter has emptied
    typedef struct {
        rgb_hsv_pkg::t_rgb pix;
        int unsigned       gap;
        bit                drain;
    } t_pixel_req;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    logic              r_valid = 1'b0;
    rgb_hsv_pkg::t_rgb r_pixel = '0;
    logic              r_ready = 1'b0;

    logic              o_ready;
    logic              o_valid;
    rgb_hsv_pkg::t_hsv o_hsv;

    t_pixel_req        pixel_backlog[$];
    rgb_hsv_pkg::t_hsv hsv_expected[$];
    t_pixel_req        staged_req;
    bit                staged = 1'b0;
    bit                burst  = 1'b0;
    bit                calm_rx = 1'b0;
    int unsigned       stall_cnt = 0;
    int unsigned       error_cnt = 0;
    int unsigned       cycle_cnt = 0;

    rgb_to_hsv_8bit i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_valid),
        .o_ready (o_ready),
        .i_pixel (r_pixel),
        .o_valid (o_valid),
        .i_ready (r_ready),
        .o_hsv   (o_hsv)
    );

    initial begin
        forever #CLK_HALF i_clk = ~i_clk;
    end

    // Integer HSV of one pixel; division truncates toward zero as for int
    function automatic rgb_hsv_pkg::t_hsv hsv_of(input rgb_hsv_pkg::t_rgb px);
        int                r, g, b, hi, lo, spread, base, diff, quot;
        rgb_hsv_pkg::t_hsv res;
        r      = px.red;
        g      = px.green;
        b      = px.blue;
        hi     = (r > g) ? r : g;
        hi     = (hi > b) ? hi : b;
        lo     = (r < g) ? r : g;
        lo     = (lo < b) ? lo : b;
        spread = hi - lo;
        res    = '0;
        if (spread != 0) begin
            // red is tested first, then green, so ties go that way
            if (hi == r) begin
                base = int'(rgb_hsv_pkg::OFS_RED);
                diff = g - b;
            end else if (hi == g) begin
                base = int'(rgb_hsv_pkg::OFS_GREEN);
                diff = b - r;
            end else begin
                base = int'(rgb_hsv_pkg::OFS_BLUE);
                diff = r - g;
            end
            quot    = (HUE_STEP * diff) / spread;
            res.hue = 8'(base + quot);
        end
        if (hi != 0) begin
            res.saturation = 8'((FULL_SCALE * spread) / hi);
        end
        res.brightness = 8'(hi);
        return res;
    endfunction

    // Queue one pixel; gap is zero inside a burst stretch
    task automatic queue_pixel(input int r, input int g, input int b, input bit drain);
        t_pixel_req req;
        req.pix.red   = 8'(r);
        req.pix.green = 8'(g);
        req.pix.blue  = 8'(b);
        req.gap       = burst ? 0 : $urandom_range(0, MAX_IDLE);
        req.drain     = drain;
        pixel_backlog.push_back(req);
    endtask

    // Driver: hold the request until taken, then stage the next one,
    // idle for its gap, and for a drain request wait for an empty pipe
    always @(posedge i_clk) begin
        bit fire;
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            staged  = 1'b0;
        end else begin
            fire = r_valid && o_ready;
            if (fire) begin
                hsv_expected.push_back(hsv_of(r_pixel));
            end
            if (!r_valid || fire) begin
                if (!staged && pixel_backlog.size() != 0) begin
                    staged_req = pixel_backlog.pop_front();
                    staged     = 1'b1;
                end
                if (staged && staged_req.gap != 0) begin
                    staged_req.gap--;
                    r_valid <= 1'b0;
                end else if (staged && staged_req.drain && hsv_expected.size() != 0) begin
                    r_valid <= 1'b0;
                end else if (staged) begin
                    r_valid <= 1'b1;
                    r_pixel <= staged_req.pix;
                    staged  = 1'b0;
                end else begin
                    r_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: check each handed-over result against the oldest prediction,
    // then stall the receiver for a drawn number of cycles
    always @(posedge i_clk) begin
        rgb_hsv_pkg::t_hsv want;
        if (!i_rst_n) begin
            r_ready   <= 1'b0;
            stall_cnt = 0;
        end else begin
            if (o_valid && r_ready) begin
                if (hsv_expected.size() == 0) begin
                    $error("result with no request outstanding: hue %0d sat %0d val %0d",
                           o_hsv.hue, o_hsv.saturation, o_hsv.brightness);
                    error_cnt++;
                end else begin
                    want = hsv_expected.pop_front();
                    if (o_hsv.hue !== want.hue) begin
                        $error("hue: expected %0d, got %0d", want.hue, o_hsv.hue);
                        error_cnt++;
                    end
                    if (o_hsv.saturation !== want.saturation) begin
                        $error("saturation: expected %0d, got %0d",
                               want.saturation, o_hsv.saturation);
                        error_cnt++;
                    end
                    if (o_hsv.brightness !== want.brightness) begin
                        $error("brightness: expected %0d, got %0d",
                               want.brightness, o_hsv.brightness);
                        error_cnt++;
                    end
                end
                if ($urandom_range(0, 39) == 0) begin
                    calm_rx = !calm_rx;
                end
                stall_cnt = calm_rx ? 0 : $urandom_range(0, MAX_IDLE);
            end else if (stall_cnt != 0) begin
                stall_cnt--;
            end
            r_ready <= (stall_cnt == 0);
        end
    end

    // Watchdog: drop the run if it has not finished well within bounds
    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial begin
        int r, g, b, lvl, mode;
        // Directed: extremes, grey, black, ties and the wrapping red sector
        queue_pixel(0, 0, 0, 1'b0);
        queue_pixel(255, 255, 255, 1'b0);
        queue_pixel(128, 128, 128, 1'b0);
        queue_pixel(1, 1, 1, 1'b0);
        queue_pixel(255, 0, 0, 1'b0);
        queue_pixel(0, 255, 0, 1'b0);
        queue_pixel(0, 0, 255, 1'b0);
        queue_pixel(255, 0, 1, 1'b0);
        queue_pixel(255, 0, 255, 1'b0);
        queue_pixel(255, 255, 0, 1'b0);
        queue_pixel(0, 255, 255, 1'b0);
        queue_pixel(255, 1, 0, 1'b0);
        queue_pixel(1, 0, 0, 1'b0);
        queue_pixel(0, 1, 0, 1'b0);
        queue_pixel(0, 0, 1, 1'b0);
        queue_pixel(255, 254, 255, 1'b0);
        queue_pixel(170, 85, 255, 1'b0);
        queue_pixel(85, 255, 170, 1'b0);
        queue_pixel(200, 100, 150, 1'b0);
        queue_pixel(255, 254, 0, 1'b0);
        queue_pixel(254, 255, 255, 1'b1);
        queue_pixel(0, 255, 1, 1'b0);

        // Random: mostly full-range pixels, with ties, near-grey and edge values
        for (int n = 0; n < RANDOM_PIX; n++) begin
            if ($urandom_range(0, 29) == 0) begin
                burst = !burst;
            end
            mode = $urandom_range(0, 9);
            r = $urandom_range(0, 255);
            g = $urandom_range(0, 255);
            b = $urandom_range(0, 255);
            case (mode)
                6: begin
                    // two channels share the maximum
                    lvl = $urandom_range(1, 255);
                    r = lvl;
                    g = lvl;
                    b = $urandom_range(0, lvl);
                    case ($urandom_range(0, 2))
                        0: begin
                            b = lvl;
                            g = $urandom_range(0, lvl);
                        end
                        1: begin
                            r = $urandom_range(0, lvl);
                            b = lvl;
                        end
                        default: ;
                    endcase
                end
                7: begin
                    // tiny spread around a random level
                    lvl = $urandom_range(0, 251);
                    r = lvl + $urandom_range(0, 4);
                    g = lvl + $urandom_range(0, 4);
                    b = lvl + $urandom_range(0, 4);
                end
                8: begin
                    r = $urandom_range(0, 1) ? 255 : 0;
                    b = $urandom_range(0, 1) ? 255 : b;
                end
                9: begin
                    r = $urandom_range(0, 255);
                    g = r;
                    b = r;
                end
                default: ;
            endcase
            queue_pixel(r, g, b, $urandom_range(0, 149) == 0);
        end

        repeat (RESET_LEN) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pixel_backlog.size() != 0 || staged || r_valid || hsv_expected.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (FLUSH_LEN) @(posedge i_clk);

        if (error_cnt == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
